// ===== sv/assert_macros.svh =====
// Assertion macros shared by the state vector engine RTL.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SVGE_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SVGE_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/svge_pkg.sv =====
// Types, constants and helper functions for the state vector gate engine.
// No dependencies; used by every module of the block except svge_ram.
package svge_pkg;

    localparam int MAX_QUBITS = 10;
    localparam int AMP_BITS   = 16;
    localparam int OUT_BITS   = 16;
    localparam int H_NUM      = 46341;
    localparam int ADDR_W     = MAX_QUBITS;
    localparam int PAIR_W     = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1;
    localparam int QN_W       = 5;
    localparam int PROD_W     = AMP_BITS + 18;

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [PAIR_W-1:0]          t_pair;
    typedef logic [QN_W-1:0]            t_qn;
    typedef logic signed [AMP_BITS-1:0] t_amp;
    typedef logic signed [AMP_BITS:0]   t_sum;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [OUT_BITS-1:0] t_out;
    typedef logic signed [15:0]         t_in_amp;

    typedef struct packed {
        t_amp re;
        t_amp im;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    typedef struct packed {
        t_amp v;
        logic sat;
    } t_rs;

    typedef struct packed {
        t_word v0;
        t_word v1;
        logic  sat0;
        logic  sat1;
    } t_bfly_out;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_READ     = 2'd1,
        CMD_HADAMARD = 2'd2,
        CMD_CNOT     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAME  = 2'd2
    } t_status;

    localparam t_prod H_COEF = t_prod'(H_NUM);
    localparam logic signed [AMP_BITS+1:0] SAT_HI = {3'b000, {(AMP_BITS-1){1'b1}}};
    localparam logic signed [AMP_BITS+1:0] SAT_LO = {3'b111, {(AMP_BITS-1){1'b0}}};

    function automatic t_qn qubits_in_use(logic [3:0] cfg);
        if (cfg == 4'd0) return t_qn'(1);
        if (int'(cfg) > MAX_QUBITS) return t_qn'(MAX_QUBITS);
        return t_qn'(cfg);
    endfunction

    // Spread a pair number around a zero at bit q.
    function automatic t_addr insert_zero(t_addr m, t_qn q);
        t_addr low_mask;
        low_mask = (t_addr'(1) << q) - t_addr'(1);
        return ((m & ~low_mask) << 1) | (m & low_mask);
    endfunction

    // Round half up after the 2^-16 scale, then clip to the amplitude range.
    function automatic t_rs round_sat(t_prod p);
        t_prod                       t;
        logic signed [AMP_BITS+1:0]  q;
        t_rs                         r;
        t = p + t_prod'(32768);
        q = (AMP_BITS+2)'(t >>> 16);
        if (q > SAT_HI) begin
            r.v   = t_amp'(SAT_HI);
            r.sat = 1'b1;
        end else if (q < SAT_LO) begin
            r.v   = t_amp'(SAT_LO);
            r.sat = 1'b1;
        end else begin
            r.v   = t_amp'(q);
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic t_amp to_amp(t_in_amp v);
        return t_amp'(v);
    endfunction

    function automatic t_out to_out(t_amp v);
        return t_out'(v);
    endfunction

endpackage

// ===== sv/svge_ram.sv =====
// Amplitude store: one write port, two registered read ports.
// Generic; no package dependencies.
module svge_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== sv/svge_bfly.sv =====
// Hadamard butterfly: registered sum and difference products, then rounding.
// Depends on svge_pkg.
module svge_bfly (
    input  logic                i_clk,
    input  logic                i_en,
    input  svge_pkg::t_word     i_w0,
    input  svge_pkg::t_word     i_w1,
    output svge_pkg::t_bfly_out o_res
);

    svge_pkg::t_prod r_p_re_s, r_p_im_s, r_p_re_d, r_p_im_d;
    svge_pkg::t_sum  re_s, im_s, re_d, im_d;
    svge_pkg::t_rs   rs_re_s, rs_im_s, rs_re_d, rs_im_d;

    assign re_s = svge_pkg::t_sum'(i_w0.re) + svge_pkg::t_sum'(i_w1.re);
    assign im_s = svge_pkg::t_sum'(i_w0.im) + svge_pkg::t_sum'(i_w1.im);
    assign re_d = svge_pkg::t_sum'(i_w0.re) - svge_pkg::t_sum'(i_w1.re);
    assign im_d = svge_pkg::t_sum'(i_w0.im) - svge_pkg::t_sum'(i_w1.im);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_re_s <= svge_pkg::t_prod'(re_s) * svge_pkg::H_COEF;
            r_p_im_s <= svge_pkg::t_prod'(im_s) * svge_pkg::H_COEF;
            r_p_re_d <= svge_pkg::t_prod'(re_d) * svge_pkg::H_COEF;
            r_p_im_d <= svge_pkg::t_prod'(im_d) * svge_pkg::H_COEF;
        end
    end

    assign rs_re_s = svge_pkg::round_sat(r_p_re_s);
    assign rs_im_s = svge_pkg::round_sat(r_p_im_s);
    assign rs_re_d = svge_pkg::round_sat(r_p_re_d);
    assign rs_im_d = svge_pkg::round_sat(r_p_im_d);

    always_comb begin
        o_res.v0.re = rs_re_s.v;
        o_res.v0.im = rs_im_s.v;
        o_res.v1.re = rs_re_d.v;
        o_res.v1.im = rs_im_d.v;
        o_res.sat0  = rs_re_s.sat | rs_im_s.sat;
        o_res.sat1  = rs_re_d.sat | rs_im_d.sat;
    end

endmodule

// ===== sv/state_vector_gate_engine_unit.sv =====
// State vector gate engine, top level: command sequencer, store and butterfly.
// Depends on svge_pkg, svge_ram, svge_bfly and assert_macros.svh.
//
// One command is taken at a time and gives one result beat. A write or a
// rejected command passes through S_FIN, a read through S_RDWAIT and S_FIN,
// before its result loads the output register; the next command is taken once
// it has loaded. A Hadamard or CNOT sweeps all 2^(n-1) amplitude pairs of the
// active n qubits in S_GATE; the single store write port takes the two writes
// of a Hadamard pair, or of a swapped CNOT pair, one after the other, overlapping
// the read of the next pair. A full output register that is stalled holds the
// sequencer for as long as the stall lasts.
// The store is not cleared at reset; read only entries that have been written.
// active_qubits values of 0 act as 1 and values above MAX_QUBITS act as
// MAX_QUBITS.
`include "assert_macros.svh"

module state_vector_gate_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [9:0]         i_amp_index,
    input  logic signed [15:0] i_amp_re,
    input  logic signed [15:0] i_amp_im,
    input  logic [3:0]         i_qubit_a,
    input  logic [3:0]         i_qubit_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_re,
    output logic signed [15:0] o_out_im,
    output logic [1:0]         o_status,
    output logic               o_saturated
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RDWAIT = 4'b0010,
        S_GATE   = 4'b0100,
        S_FIN    = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [3:0]          r_active;
    svge_pkg::t_cmd      r_cmd;
    svge_pkg::t_qn       r_tq;
    svge_pkg::t_addr     r_cbit;
    svge_pkg::t_pair     r_pair;
    logic                r_issue_on, r_ph, r_mv, r_wv;
    svge_pkg::t_addr     r_k_m, r_p_m, r_k_w, r_p_w;
    logic                r_swap_m, r_swap_w;
    svge_pkg::t_word     r_cw0, r_cw1;
    svge_pkg::t_status   r_res_status;
    logic                r_sat, r_is_read;

    logic                r_out_valid, r_out_sat;
    svge_pkg::t_out      r_out_re, r_out_im;
    svge_pkg::t_status   r_out_status;

    svge_pkg::t_qn       nq;
    svge_pkg::t_cmd      in_cmd;
    logic                acc, idx_bad, qa_bad, qb_bad, out_free, last_pair;
    logic                issue, m_step, w0_step, w1_step, is_h;
    svge_pkg::t_addr     k_addr, t_bit;

    logic                ram_we, ram_re;
    svge_pkg::t_addr     ram_waddr, ram_raddr_a, ram_raddr_b;
    svge_pkg::t_word     ram_wdata, ram_rdata_a, ram_rdata_b;
    svge_pkg::t_bfly_out bfly;

    assign nq       = svge_pkg::qubits_in_use(r_active);
    assign in_cmd   = svge_pkg::t_cmd'(i_cmd);
    assign o_stall  = (r_state != S_IDLE);
    assign acc      = i_valid && (r_state == S_IDLE);
    assign idx_bad  = (i_amp_index >> nq) != 10'd0;
    assign qa_bad   = svge_pkg::t_qn'(i_qubit_a) >= nq;
    assign qb_bad   = svge_pkg::t_qn'(i_qubit_b) >= nq;
    assign out_free = !r_out_valid || !i_stall;
    assign is_h     = (r_cmd == svge_pkg::CMD_HADAMARD);

    assign k_addr    = svge_pkg::insert_zero(svge_pkg::t_addr'(r_pair), r_tq);
    assign t_bit     = svge_pkg::t_addr'(1) << r_tq;
    assign last_pair = svge_pkg::t_addr'(r_pair) ==
                       ((svge_pkg::t_addr'(1) << (nq - svge_pkg::t_qn'(1))) -
                        svge_pkg::t_addr'(1));

    assign issue   = (r_state == S_GATE) && !r_ph && r_issue_on;
    assign m_step  = (r_state == S_GATE) && r_ph && r_mv;
    assign w0_step = (r_state == S_GATE) && !r_ph && r_wv;
    assign w1_step = (r_state == S_GATE) && r_ph && r_wv;

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_k_w;
        ram_wdata   = is_h ? bfly.v0 : r_cw0;
        ram_re      = 1'b0;
        ram_raddr_a = k_addr;
        ram_raddr_b = k_addr | t_bit;
        if (acc) begin
            ram_waddr        = svge_pkg::t_addr'(i_amp_index);
            ram_wdata.re     = svge_pkg::to_amp(i_amp_re);
            ram_wdata.im     = svge_pkg::to_amp(i_amp_im);
            ram_raddr_a      = svge_pkg::t_addr'(i_amp_index);
            ram_we           = (in_cmd == svge_pkg::CMD_WRITE) && !idx_bad;
            ram_re           = (in_cmd == svge_pkg::CMD_READ) && !idx_bad;
        end else if (w0_step) begin
            ram_we = is_h || r_swap_w;
            ram_re = issue;
        end else if (w1_step) begin
            ram_we    = is_h || r_swap_w;
            ram_waddr = r_p_w;
            ram_wdata = is_h ? bfly.v1 : r_cw1;
        end else begin
            ram_re = issue;
        end
    end

    svge_ram #(
        .ADDR_W (svge_pkg::ADDR_W),
        .DATA_W (svge_pkg::WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    svge_bfly u_bfly (
        .i_clk (i_clk),
        .i_en  (m_step && is_h),
        .i_w0  (ram_rdata_a),
        .i_w1  (ram_rdata_b),
        .o_res (bfly)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (in_cmd)
                        svge_pkg::CMD_READ:     n_state = idx_bad ? S_FIN : S_RDWAIT;
                        svge_pkg::CMD_HADAMARD: n_state = qa_bad ? S_FIN : S_GATE;
                        svge_pkg::CMD_CNOT: begin
                            n_state = (qa_bad || qb_bad || i_qubit_a == i_qubit_b) ?
                                      S_FIN : S_GATE;
                        end
                        default:                n_state = S_FIN;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_FIN;
            S_GATE: begin
                if (w1_step && !r_mv && !r_issue_on) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 4'd10;
            r_issue_on  <= 1'b0;
            r_ph        <= 1'b0;
            r_mv        <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end

            if (acc) begin
                r_cmd        <= in_cmd;
                r_pair       <= '0;
                r_issue_on   <= 1'b1;
                r_ph         <= 1'b0;
                r_mv         <= 1'b0;
                r_wv         <= 1'b0;
                r_sat        <= 1'b0;
                r_is_read    <= (in_cmd == svge_pkg::CMD_READ) && !idx_bad;
                r_cbit       <= svge_pkg::t_addr'(1) << svge_pkg::t_qn'(i_qubit_a);
                r_res_status <= svge_pkg::ST_OK;
                case (in_cmd)
                    svge_pkg::CMD_HADAMARD: begin
                        r_tq <= svge_pkg::t_qn'(i_qubit_a);
                        if (qa_bad) begin
                            r_res_status <= svge_pkg::ST_RANGE;
                        end
                    end
                    svge_pkg::CMD_CNOT: begin
                        r_tq <= svge_pkg::t_qn'(i_qubit_b);
                        if (qa_bad || qb_bad) begin
                            r_res_status <= svge_pkg::ST_RANGE;
                        end else if (i_qubit_a == i_qubit_b) begin
                            r_res_status <= svge_pkg::ST_SAME;
                        end
                    end
                    default: begin
                        r_tq <= '0;
                        if (idx_bad) begin
                            r_res_status <= svge_pkg::ST_RANGE;
                        end
                    end
                endcase
            end else if (r_state == S_GATE) begin
                r_ph <= ~r_ph;
                if (issue) begin
                    r_mv     <= 1'b1;
                    r_k_m    <= k_addr;
                    r_p_m    <= k_addr | t_bit;
                    r_swap_m <= (k_addr & r_cbit) != '0;
                    if (last_pair) begin
                        r_issue_on <= 1'b0;
                    end else begin
                        r_pair <= r_pair + svge_pkg::t_pair'(1);
                    end
                end else if (r_ph) begin
                    r_mv <= 1'b0;
                end
                if (m_step) begin
                    r_wv     <= 1'b1;
                    r_k_w    <= r_k_m;
                    r_p_w    <= r_p_m;
                    r_swap_w <= r_swap_m;
                    r_cw0    <= ram_rdata_b;
                    r_cw1    <= ram_rdata_a;
                end else if (w1_step) begin
                    r_wv <= 1'b0;
                end
                if (is_h && ((w0_step && bfly.sat0) || (w1_step && bfly.sat1))) begin
                    r_sat <= 1'b1;
                end
            end

            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_re     <= r_is_read ? svge_pkg::to_out(ram_rdata_a.re) : '0;
            r_out_im     <= r_is_read ? svge_pkg::to_out(ram_rdata_a.im) : '0;
            r_out_status <= r_res_status;
            r_out_sat    <= r_sat && is_h;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_status    = r_out_status;
    assign o_saturated = r_out_sat;

    `SVGE_CHECK(a_idle_drained, !o_stall |-> (!r_mv && !r_wv), "pair pipeline busy while idle")
    `SVGE_CHECK(a_m_phase, r_mv |-> (r_state == S_GATE && r_ph), "read data stage out of phase")
    `SVGE_CHECK(a_w_in_gate, r_wv |-> (r_state == S_GATE), "write-back pending outside gate")
    `SVGE_CHECK_NEXT(a_fin_loads, (r_state == S_FIN && out_free), o_valid, "result beat lost")

endmodule

// ===== test/state_vector_gate_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for state_vector_gate_engine_unit: amplitude writes, reads, Hadamard and CNOT
// checked beat by beat against an in-bench model of the amplitude store.
// Depends on svge_pkg and the engine RTL.
module state_vector_gate_engine_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int FILL_MAX_N     = 6;

    typedef struct {
        svge_pkg::t_cmd     cmd;
        logic [9:0]         index;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [3:0]         qa;
        logic [3:0]         qb;
    } t_gate_req;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        svge_pkg::t_status  status;
        logic               sat;
    } t_amp_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [3:0]         i_cfg_data = 4'd0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd = 2'd0;
    logic [9:0]         i_amp_index = 10'd0;
    logic signed [15:0] i_amp_re = 16'sd0;
    logic signed [15:0] i_amp_im = 16'sd0;
    logic [3:0]         i_qubit_a = 4'd0;
    logic [3:0]         i_qubit_b = 4'd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_out_re;
    logic signed [15:0] o_out_im;
    logic [1:0]         o_status;
    logic               o_saturated;

    // model of the amplitude store
    logic signed [15:0] sv_re [1024];
    logic signed [15:0] sv_im [1024];
    bit                 sv_known [1024];
    logic [3:0]         qubits_reg = 4'd10;

    t_amp_beat amp_results_due[$];
    int        fails = 0;
    int        stall_pct = 0;
    bit        bursty = 1'b0;
    int        burst_left = 0;
    int        stuck_cycles = 0;
    logic [4:0] stall_tick = 5'd0;

    state_vector_gate_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_amp_index (i_amp_index),
        .i_amp_re    (i_amp_re),
        .i_amp_im    (i_amp_im),
        .i_qubit_a   (i_qubit_a),
        .i_qubit_b   (i_qubit_b),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_status    (o_status),
        .o_saturated (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_n();
        if (qubits_reg == 4'd0) return 1;
        if (int'(qubits_reg) > svge_pkg::MAX_QUBITS) return svge_pkg::MAX_QUBITS;
        return int'(qubits_reg);
    endfunction

    // x * 46341 / 65536, round half up, clip
    function automatic logic signed [15:0] h_scale(int s, inout bit clipped);
        longint t;
        t = longint'(s) * svge_pkg::H_NUM + 32768;
        t = t >>> 16;
        if (t > 32767) begin
            clipped = 1'b1;
            return 16'sh7fff;
        end
        if (t < -32768) begin
            clipped = 1'b1;
            return 16'sh8000;
        end
        return 16'(t);
    endfunction

    function automatic t_amp_beat apply_gate(t_gate_req g);
        t_amp_beat b;
        int        n;
        int        size;
        int        qbit;
        int        tbit;
        int        p;
        int        r0, r1, m0, m1;
        bit        clipped;
        logic signed [15:0] t;
        n = active_n();
        size = 1 << n;
        b.re = 16'sd0;
        b.im = 16'sd0;
        b.status = svge_pkg::ST_OK;
        clipped = 1'b0;
        case (g.cmd)
            svge_pkg::CMD_WRITE: begin
                if (int'(g.index) >= size) begin
                    b.status = svge_pkg::ST_RANGE;
                end else begin
                    sv_re[g.index] = g.re;
                    sv_im[g.index] = g.im;
                    sv_known[g.index] = 1'b1;
                end
            end
            svge_pkg::CMD_READ: begin
                if (int'(g.index) >= size) begin
                    b.status = svge_pkg::ST_RANGE;
                end else begin
                    b.re = sv_re[g.index];
                    b.im = sv_im[g.index];
                end
            end
            svge_pkg::CMD_HADAMARD: begin
                if (int'(g.qa) >= n) begin
                    b.status = svge_pkg::ST_RANGE;
                end else begin
                    qbit = 1 << g.qa;
                    for (int k = 0; k < size; k++) begin
                        if ((k & qbit) == 0) begin
                            p = k | qbit;
                            r0 = sv_re[k];
                            r1 = sv_re[p];
                            m0 = sv_im[k];
                            m1 = sv_im[p];
                            sv_re[k] = h_scale(r0 + r1, clipped);
                            sv_re[p] = h_scale(r0 - r1, clipped);
                            sv_im[k] = h_scale(m0 + m1, clipped);
                            sv_im[p] = h_scale(m0 - m1, clipped);
                        end
                    end
                end
            end
            svge_pkg::CMD_CNOT: begin
                if (int'(g.qa) >= n || int'(g.qb) >= n) begin
                    b.status = svge_pkg::ST_RANGE;
                end else if (g.qa == g.qb) begin
                    b.status = svge_pkg::ST_SAME;
                end else begin
                    qbit = 1 << g.qa;
                    tbit = 1 << g.qb;
                    for (int k = 0; k < size; k++) begin
                        if ((k & qbit) != 0 && (k & tbit) != 0) begin
                            p = k ^ tbit;
                            t = sv_re[k]; sv_re[k] = sv_re[p]; sv_re[p] = t;
                            t = sv_im[k]; sv_im[k] = sv_im[p]; sv_im[p] = t;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        b.sat = clipped;
        return b;
    endfunction

    // true if the command would touch a never-written entry
    function automatic bit touches_unknown(t_gate_req g);
        int n;
        int size;
        bit sweep;
        n = active_n();
        size = 1 << n;
        sweep = 1'b0;
        case (g.cmd)
            svge_pkg::CMD_READ:     return int'(g.index) < size && !sv_known[g.index];
            svge_pkg::CMD_HADAMARD: sweep = int'(g.qa) < n;
            svge_pkg::CMD_CNOT:     sweep = int'(g.qa) < n && int'(g.qb) < n && g.qa != g.qb;
            default:                sweep = 1'b0;
        endcase
        if (sweep) begin
            for (int k = 0; k < size; k++) begin
                if (!sv_known[k]) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_gate_req mk_req(svge_pkg::t_cmd c, int idx, int re, int im,
                                         int qa, int qb);
        t_gate_req g;
        g.cmd = c;
        g.index = 10'(idx);
        g.re = 16'(re);
        g.im = 16'(im);
        g.qa = 4'(qa);
        g.qb = 4'(qb);
        return g;
    endfunction

    function automatic logic signed [15:0] rand_amp();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'(int'($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_gate_req rand_req();
        t_gate_req g;
        int        n;
        int        pick;
        n = active_n();
        g.index = 10'($urandom);
        g.re = rand_amp();
        g.im = rand_amp();
        g.qa = 4'($urandom);
        g.qb = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) g.cmd = svge_pkg::CMD_WRITE;
        else if (pick < 60) g.cmd = svge_pkg::CMD_READ;
        else if (pick < 80) g.cmd = svge_pkg::CMD_HADAMARD;
        else g.cmd = svge_pkg::CMD_CNOT;
        case (g.cmd)
            svge_pkg::CMD_WRITE, svge_pkg::CMD_READ: begin
                if ($urandom_range(0, 9) != 0) g.index = 10'($urandom_range(0, (1 << n) - 1));
            end
            svge_pkg::CMD_HADAMARD: begin
                if ($urandom_range(0, 7) != 0) g.qa = 4'($urandom_range(0, n - 1));
            end
            default: begin
                pick = $urandom_range(0, 9);
                if (pick == 1) begin
                    g.qa = 4'($urandom_range(0, n - 1));
                    g.qb = g.qa;
                end else if (pick != 0 && n > 1) begin
                    g.qa = 4'($urandom_range(0, n - 1));
                    g.qb = 4'((int'(g.qa) + int'($urandom_range(1, n - 1))) % n);
                end
            end
        endcase
        return g;
    endfunction

    function automatic void queue_result(t_amp_beat b);
        amp_results_due = {amp_results_due, b};
    endfunction

    task automatic send_req(t_gate_req g);
        int n;
        n = active_n();
        if (touches_unknown(g)) begin
            g.cmd = svge_pkg::CMD_WRITE;
            for (int k = (1 << n) - 1; k >= 0; k--) begin
                if (!sv_known[k]) g.index = 10'(k);
            end
        end
        i_valid <= 1'b1;
        i_cmd <= g.cmd;
        i_amp_index <= g.index;
        i_amp_re <= g.re;
        i_amp_im <= g.im;
        i_qubit_a <= g.qa;
        i_qubit_b <= g.qb;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        queue_result(apply_gate(g));
    endtask

    task automatic pace();
        int gap;
        if (bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 10);
                burst_left = $urandom_range(1, 20);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (amp_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_qubits(logic [3:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        qubits_reg = v;
    endtask

    task automatic test_reset_width();
        stall_pct = 25;
        send_req(mk_req(svge_pkg::CMD_WRITE, 1023, -32768, 32767, 0, 0));
        send_req(mk_req(svge_pkg::CMD_READ, 1023, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_HADAMARD, 0, 0, 0, 10, 0));
        send_req(mk_req(svge_pkg::CMD_CNOT, 0, 0, 0, 9, 9));
        send_req(mk_req(svge_pkg::CMD_CNOT, 0, 0, 0, 15, 15));
    endtask

    task automatic test_single_qubit();
        set_qubits(4'd0);
        send_req(mk_req(svge_pkg::CMD_WRITE, 0, -32768, 32767, 0, 0));
        send_req(mk_req(svge_pkg::CMD_WRITE, 1, 32767, -32768, 0, 0));
        send_req(mk_req(svge_pkg::CMD_WRITE, 1023, 1, 1, 0, 0));
        send_req(mk_req(svge_pkg::CMD_READ, 1023, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_HADAMARD, 0, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_READ, 0, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_READ, 1, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_CNOT, 0, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_CNOT, 0, 0, 0, 0, 1));
        send_req(mk_req(svge_pkg::CMD_HADAMARD, 0, 0, 0, 15, 15));
    endtask

    // sums of +/-32768 land exactly on a half
    task automatic test_half_rounding();
        set_qubits(4'd1);
        send_req(mk_req(svge_pkg::CMD_WRITE, 0, 16384, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_WRITE, 1, 16384, -32768, 0, 0));
        send_req(mk_req(svge_pkg::CMD_HADAMARD, 0, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_READ, 0, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_READ, 1, 0, 0, 0, 0));
    endtask

    task automatic test_register_ceiling();
        set_qubits(4'd15);
        send_req(mk_req(svge_pkg::CMD_READ, 1023, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_WRITE, 512, 32767, -1, 0, 0));
        send_req(mk_req(svge_pkg::CMD_READ, 512, 0, 0, 0, 0));
        send_req(mk_req(svge_pkg::CMD_HADAMARD, 0, 0, 0, 12, 0));
        send_req(mk_req(svge_pkg::CMD_CNOT, 0, 0, 0, 3, 3));
    endtask

    task automatic test_random_traffic(logic [3:0] cfg, int count, bit gaps, int stall);
        int n;
        set_qubits(cfg);
        bursty = gaps;
        stall_pct = stall;
        burst_left = 0;
        n = active_n();
        if (n <= FILL_MAX_N) begin
            for (int k = 0; k < (1 << n); k++) begin
                if (!sv_known[k]) begin
                    send_req(mk_req(svge_pkg::CMD_WRITE, k, rand_amp(), rand_amp(),
                                    $urandom, $urandom));
                    pace();
                end
            end
        end
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            send_req(rand_req());
            pace();
        end
    endtask

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 5'd1;
        i_stall <= (stall_pct != 0) &&
                   (($urandom_range(0, 99) < stall_pct) || (stall_tick[4:2] == 3'd7));
    end

    always @(posedge i_clk) begin
        t_amp_beat want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (amp_results_due.size() == 0) begin
                $error("result beat with nothing pending");
                fails++;
            end else begin
                want = amp_results_due.pop_front();
                if (o_out_re !== want.re) begin
                    $error("out_re: expected %0d, got %0d", want.re, o_out_re);
                    fails++;
                end
                if (o_out_im !== want.im) begin
                    $error("out_im: expected %0d, got %0d", want.im, o_out_im);
                    fails++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fails++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, o_saturated);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("[state_vector_gate_engine_unit] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_width();
        test_single_qubit();
        test_half_rounding();
        test_register_ceiling();
        test_random_traffic(4'd2, 80, 1'b1, 30);
        test_random_traffic(4'd3, 80, 1'b0, 0);
        test_random_traffic(4'd5, 100, 1'b1, 50);
        test_random_traffic(4'd1, 40, 1'b1, 20);
        test_random_traffic(4'd6, 100, 1'b1, 70);
        test_random_traffic(4'd4, 60, 1'b0, 40);
        test_random_traffic(4'd12, 60, 1'b1, 30);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("[state_vector_gate_engine_unit] OK");
        end else begin
            $display("[state_vector_gate_engine_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/svge_pkg.sv
sv/svge_ram.sv
sv/svge_bfly.sv
sv/state_vector_gate_engine_unit.sv
test/state_vector_gate_engine_unit_tb.sv
